>>> hw/rtl/wavhp_pkg.sv
// wavhp_pkg: shared types, codes and constants of the wav pcm16 header parser
// no dependencies; imported by the interfaces, the chunk walker and the top level

package wavhp_pkg;

  // parse phase of the byte walker
  typedef enum logic [1:0] {
    PH_PREAMBLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_PAD
  } wavhp_phase_e;

  // kind of the chunk being walked
  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_FMT,
    KIND_DATA
  } wavhp_kind_e;

  // result status, first matching check wins
  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_WAV,
    ST_TRUNCATED,
    ST_BAD_FMT_SIZE,
    ST_MISSING_CHUNK,
    ST_NOT_PCM16,
    ST_CHAN_MISMATCH,
    ST_RATE_MISMATCH
  } wavhp_status_e;

  // configuration register indexes
  localparam logic [7:0] CFG_EXP_CHANNELS = 8'd0;
  localparam logic [7:0] CFG_EXP_RATE     = 8'd1;

  localparam logic [15:0] EXP_CHANNELS_RST = 16'd1;
  localparam logic [31:0] EXP_RATE_RST     = 32'd16000;

  // chunk tags as little-endian words
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [32:0] POS_MAX = 33'h1_FFFF_FFFF;
  // a file shorter than 44 bytes means the last byte sits below offset 43
  localparam logic [32:0] MIN_LAST_POS = 33'd43;
  localparam logic [3:0]  LAST_PREAMBLE_POS = 4'd11;
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  // fmt payload byte positions
  localparam logic [4:0] FMT_FIELDS_END = 5'd8;
  localparam logic [4:0] FMT_BITS_LO    = 5'd14;
  localparam logic [4:0] FMT_BITS_HI    = 5'd15;
  localparam logic [4:0] FMT_IDX_MAX    = 5'd16;

  localparam logic [15:0] FMT_PCM  = 16'd1;
  localparam logic [15:0] PCM_BITS = 16'd16;

  typedef struct packed {
    logic [15:0] exp_channels;
    logic [31:0] exp_rate;
  } wavhp_cfg_t;

  typedef struct packed {
    wavhp_status_e status;
    logic [15:0]   channel_count;
    logic [31:0]   rate_hz;
    logic [31:0]   payload_off;
    logic [31:0]   payload_len;
  } wavhp_result_t;

  // expected byte of the riff/wave preamble
  function automatic logic [7:0] preamble_tag(input logic [3:0] idx);
    logic [7:0] tag;
    case (idx)
      4'd0:    tag = 8'h52;
      4'd1:    tag = 8'h49;
      4'd2:    tag = 8'h46;
      4'd3:    tag = 8'h46;
      4'd8:    tag = 8'h57;
      4'd9:    tag = 8'h41;
      4'd10:   tag = 8'h56;
      4'd11:   tag = 8'h45;
      default: tag = 8'h00;
    endcase
    return tag;
  endfunction

  // preamble offsets that carry a tag byte (the riff size is not checked)
  function automatic logic preamble_checked(input logic [3:0] idx);
    return (idx < 4'd4) || ((idx >= 4'd8) && (idx <= LAST_PREAMBLE_POS));
  endfunction

endpackage

>>> hw/rtl/wavhp_if.sv
// wavhp interfaces: byte input, result output and configuration write channels
// depends on wavhp_pkg for the result status type

interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       is_last;

  modport source (output valid, file_byte, is_last, input ready);
  modport sink   (input valid, file_byte, is_last, output ready);
endinterface

interface wavhp_out_if;
  import wavhp_pkg::*;
  logic          valid;
  logic          ready;
  wavhp_status_e status;
  logic [15:0]   channel_count;
  logic [31:0]   rate_hz;
  logic [31:0]   payload_off;
  logic [31:0]   payload_len;

  modport source (output valid, status, channel_count, rate_hz, payload_off, payload_len,
                  input ready);
  modport sink   (input valid, status, channel_count, rate_hz, payload_off, payload_len,
                  output ready);
endinterface

interface wavhp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> hw/rtl/wavhp_walker.sv
// wavhp_walker: parse state and per-byte update of the riff/wave chunk walk
// depends on wavhp_pkg; driven one byte per step by the top level

module wavhp_walker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [7:0]               byte_i,
  input  logic                     last_i,
  input  wavhp_pkg::wavhp_cfg_t    cfg_i,
  output wavhp_pkg::wavhp_result_t res_o
);
  import wavhp_pkg::*;

  // control state, cleared at reset and after each last byte
  logic [32:0]  pos_q, pos_d;
  wavhp_phase_e phase_q, phase_d;
  logic         tags_ok_q, tags_ok_d;
  logic [2:0]   hdr_cnt_q, hdr_cnt_d;
  logic         fmt_err_q, fmt_err_d;
  logic         seen_fmt_q, seen_fmt_d;
  logic         seen_data_q, seen_data_d;
  logic [15:0]  com_fmt_q, com_fmt_d;
  logic [15:0]  com_ch_q, com_ch_d;
  logic [31:0]  com_rate_q, com_rate_d;
  logic [15:0]  com_bits_q, com_bits_d;
  logic [31:0]  data_off_q, data_off_d;
  logic [31:0]  pay_len_q, pay_len_d;

  // chunk state, always written before it is read
  logic [55:0]  hdr_q, hdr_d;
  wavhp_kind_e  kind_q, kind_d;
  logic [31:0]  len_q, len_d;
  logic [31:0]  remain_q, remain_d;
  logic [4:0]   fmt_idx_q, fmt_idx_d;
  logic [63:0]  pend_q, pend_d;
  logic [15:0]  pend_bits_q, pend_bits_d;

  logic         finish;
  logic [31:0]  hdr_tag;
  logic [31:0]  hdr_len;
  logic [31:0]  next_pos;

  assign hdr_tag  = hdr_q[31:0];
  assign hdr_len  = {byte_i, hdr_q[55:32]};
  assign next_pos = pos_q[31:0] + 32'd1;

  // per-byte update
  always_comb begin
    pos_d       = (pos_q == POS_MAX) ? pos_q : pos_q + 33'd1;
    phase_d     = phase_q;
    tags_ok_d   = tags_ok_q;
    hdr_cnt_d   = hdr_cnt_q;
    fmt_err_d   = fmt_err_q;
    seen_fmt_d  = seen_fmt_q;
    seen_data_d = seen_data_q;
    com_fmt_d   = com_fmt_q;
    com_ch_d    = com_ch_q;
    com_rate_d  = com_rate_q;
    com_bits_d  = com_bits_q;
    data_off_d  = data_off_q;
    pay_len_d   = pay_len_q;
    hdr_d       = hdr_q;
    kind_d      = kind_q;
    len_d       = len_q;
    remain_d    = remain_q;
    fmt_idx_d   = fmt_idx_q;
    pend_d      = pend_q;
    pend_bits_d = pend_bits_q;
    finish      = 1'b0;

    unique case (phase_q)
      PH_PREAMBLE: begin
        if (preamble_checked(pos_q[3:0]) && (byte_i != preamble_tag(pos_q[3:0]))) begin
          tags_ok_d = 1'b0;
        end
        if (pos_q[3:0] == LAST_PREAMBLE_POS) begin
          phase_d   = PH_HEADER;
          hdr_cnt_d = 3'd0;
        end
      end
      PH_HEADER: begin
        if (hdr_cnt_q != 3'd7) begin
          hdr_d[{hdr_cnt_q, 3'b000} +: 8] = byte_i;
          hdr_cnt_d = hdr_cnt_q + 3'd1;
        end else begin
          hdr_cnt_d = 3'd0;
          if (hdr_tag == TAG_FMT) begin
            kind_d = KIND_FMT;
          end else if (hdr_tag == TAG_DATA) begin
            kind_d = KIND_DATA;
          end else begin
            kind_d = KIND_OTHER;
          end
          len_d     = hdr_len;
          remain_d  = hdr_len;
          fmt_idx_d = 5'd0;
          if (hdr_len == 32'd0) begin
            finish = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        // capture format, channels and rate, then bits per sample
        if (kind_q == KIND_FMT) begin
          if (fmt_idx_q < FMT_FIELDS_END) begin
            pend_d[{fmt_idx_q[2:0], 3'b000} +: 8] = byte_i;
          end else if (fmt_idx_q == FMT_BITS_LO) begin
            pend_bits_d[7:0] = byte_i;
          end else if (fmt_idx_q == FMT_BITS_HI) begin
            pend_bits_d[15:8] = byte_i;
          end
        end
        if (fmt_idx_q != FMT_IDX_MAX) begin
          fmt_idx_d = fmt_idx_q + 5'd1;
        end
        remain_d = remain_q - 32'd1;
        if (remain_q == 32'd1) begin
          finish = 1'b1;
        end
      end
      PH_PAD: begin
        phase_d   = PH_HEADER;
        hdr_cnt_d = 3'd0;
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    // end of a chunk payload: commit unless an error is already latched
    if (finish) begin
      if (!fmt_err_q) begin
        if (kind_d == KIND_FMT) begin
          if (len_d < FMT_MIN_LEN) begin
            fmt_err_d = 1'b1;
          end else begin
            com_fmt_d  = pend_d[15:0];
            com_ch_d   = pend_d[31:16];
            com_rate_d = pend_d[63:32];
            com_bits_d = pend_bits_d;
            seen_fmt_d = 1'b1;
          end
        end else if (kind_d == KIND_DATA) begin
          data_off_d  = next_pos - len_d;
          pay_len_d   = len_d;
          seen_data_d = 1'b1;
        end
      end
      hdr_cnt_d = 3'd0;
      phase_d   = len_d[0] ? PH_PAD : PH_HEADER;
    end
  end

  // status of the file ending with this byte
  always_comb begin
    if ((pos_q < MIN_LAST_POS) || !tags_ok_d) begin
      res_o.status = ST_NOT_WAV;
    end else if (fmt_err_d) begin
      res_o.status = ST_BAD_FMT_SIZE;
    end else if (phase_d == PH_PAYLOAD) begin
      res_o.status = ST_TRUNCATED;
    end else if (!seen_fmt_d || !seen_data_d) begin
      res_o.status = ST_MISSING_CHUNK;
    end else if ((com_fmt_d != FMT_PCM) || (com_bits_d != PCM_BITS)) begin
      res_o.status = ST_NOT_PCM16;
    end else if (com_ch_d != cfg_i.exp_channels) begin
      res_o.status = ST_CHAN_MISMATCH;
    end else if (com_rate_d != cfg_i.exp_rate) begin
      res_o.status = ST_RATE_MISMATCH;
    end else begin
      res_o.status = ST_OK;
    end
    res_o.channel_count = com_ch_d;
    res_o.rate_hz       = com_rate_d;
    res_o.payload_off   = data_off_d;
    res_o.payload_len   = pay_len_d;
  end

  // control state registers, cleared again after the last byte of a file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PH_PREAMBLE;
      tags_ok_q   <= 1'b1;
      hdr_cnt_q   <= '0;
      fmt_err_q   <= 1'b0;
      seen_fmt_q  <= 1'b0;
      seen_data_q <= 1'b0;
      com_fmt_q   <= '0;
      com_ch_q    <= '0;
      com_rate_q  <= '0;
      com_bits_q  <= '0;
      data_off_q  <= '0;
      pay_len_q   <= '0;
    end else if (step_i && last_i) begin
      pos_q       <= '0;
      phase_q     <= PH_PREAMBLE;
      tags_ok_q   <= 1'b1;
      hdr_cnt_q   <= '0;
      fmt_err_q   <= 1'b0;
      seen_fmt_q  <= 1'b0;
      seen_data_q <= 1'b0;
      com_fmt_q   <= '0;
      com_ch_q    <= '0;
      com_rate_q  <= '0;
      com_bits_q  <= '0;
      data_off_q  <= '0;
      pay_len_q   <= '0;
    end else if (step_i) begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      tags_ok_q   <= tags_ok_d;
      hdr_cnt_q   <= hdr_cnt_d;
      fmt_err_q   <= fmt_err_d;
      seen_fmt_q  <= seen_fmt_d;
      seen_data_q <= seen_data_d;
      com_fmt_q   <= com_fmt_d;
      com_ch_q    <= com_ch_d;
      com_rate_q  <= com_rate_d;
      com_bits_q  <= com_bits_d;
      data_off_q  <= data_off_d;
      pay_len_q   <= pay_len_d;
    end
  end

  // chunk payload registers
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hdr_q       <= hdr_d;
      kind_q      <= kind_d;
      len_q       <= len_d;
      remain_q    <= remain_d;
      fmt_idx_q   <= fmt_idx_d;
      pend_q      <= pend_d;
      pend_bits_q <= pend_bits_d;
    end
  end

endmodule

>>> hw/rtl/wav_pcm16_header_parser_core.sv
// A WAV file enters one byte per beat and the block accepts one byte every cycle, with no gaps
// between files, unless input stalls as below; an accepted byte is held in the input register,
// and the one marked last yields its single result beat in the output register behind it.
// The rate is set by the per-byte update of the chunk walker. Input stalls only while a
// finished result waits in the output register and the byte in hand is itself a last byte.
// Configuration writes are always taken and should be made only while the block is idle.

// wav_pcm16_header_parser_core: top level with input register, result register and config
// depends on wavhp_pkg, the wavhp interfaces and wavhp_walker

module wav_pcm16_header_parser_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  wavhp_in_if.sink    in_i,
  wavhp_out_if.source out_o,
  wavhp_cfg_if.sink   cfg_i
);
  import wavhp_pkg::*;

  logic          in_vld_q;
  logic [7:0]    byte_q;
  logic          last_q;
  logic          out_vld_q;
  wavhp_result_t res_q;
  wavhp_result_t res;
  wavhp_cfg_t    cfg_q;
  logic          advance;

  // the held byte moves on unless it would need the occupied result slot
  assign advance     = in_vld_q && (!last_q || !out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.file_byte;
      last_q <= in_i.is_last;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.exp_channels <= EXP_CHANNELS_RST;
      cfg_q.exp_rate     <= EXP_RATE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_EXP_CHANNELS: cfg_q.exp_channels <= cfg_i.wdata[15:0];
        CFG_EXP_RATE:     cfg_q.exp_rate     <= cfg_i.wdata;
        default:          ;
      endcase
    end
  end

  wavhp_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (byte_q),
    .last_i (last_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = res_q.status;
  assign out_o.channel_count = res_q.channel_count;
  assign out_o.rate_hz       = res_q.rate_hz;
  assign out_o.payload_off   = res_q.payload_off;
  assign out_o.payload_len   = res_q.payload_len;

endmodule

>>> hw/rtl/wavhp_checker.sv
// wavhp_checker: port-level assertions for the wav pcm16 header parser, bound to its top level
// depends on wav_pcm16_header_parser_core and the wavhp interfaces

module wavhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_status_i,
  input logic [31:0] out_offset_i
);

  logic [1:0] pend_q;
  logic       in_last_beat;
  logic       out_beat;

  assign in_last_beat = in_valid_i && in_ready_i && in_last_i;
  assign out_beat     = out_valid_i && out_ready_i;

  // last beats taken in whose result has not yet left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (in_last_beat && !out_beat) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_beat && !in_last_beat) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  // a result beat always answers an earlier last byte
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != 2'd0))
    else $error("result shown with no last byte outstanding");

  // at most one file in the input register and one in the result register
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two files outstanding");

  // input only stalls behind a waiting result
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with the result slot empty");

  // a stalled result holds its status and offset
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_status_i)
                                        && $stable(out_offset_i)))
    else $error("stalled result changed");

endmodule

bind wav_pcm16_header_parser_core wavhp_checker u_wavhp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_last_i    (in_i.is_last),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_offset_i (out_o.payload_off)
);
